// ===== rtl/idei_pkg.sv =====
`timescale 1ns / 1ps
package idei_pkg;

    localparam int DW   = 7;   // stored hop distance
    localparam int CFGW = 7;   // configuration register width
    localparam int SUMW = 9;   // path length through the new edge

    typedef logic [DW-1:0]   t_dist;
    typedef logic [SUMW-1:0] t_sum;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_ALT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_DUP = 2'd1,
        ST_BAD = 2'd2,
        ST_RSV = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_NUMV  = 1'b0,
        CFG_GIRTH = 1'b1
    } t_cfg_idx;

    // result of one pair relaxation
    typedef struct packed {
        logic  upd;    // shorter path found
        logic  drop;   // pair falls below girth-1
        t_dist dnew;   // new distance
    } t_relax;

endpackage

// ===== rtl/idei_ram.sv =====
`timescale 1ns / 1ps
module idei_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    output logic [WIDTH-1:0]         o_rdata0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// ===== rtl/idei_relax.sv =====
`timescale 1ns / 1ps
module idei_relax (
    input  idei_pkg::t_dist  i_xa,
    input  idei_pkg::t_dist  i_xb,
    input  idei_pkg::t_dist  i_ya,
    input  idei_pkg::t_dist  i_yb,
    input  idei_pkg::t_dist  i_old,
    input  logic [6:0]       i_girth,
    output idei_pkg::t_relax o_res
);
    import idei_pkg::*;

    t_sum  p1, p2, m, old_w, thr_w;
    t_dist thr;

    always_comb begin
        p1    = t_sum'(i_xa) + t_sum'(1) + t_sum'(i_yb);
        p2    = t_sum'(i_xb) + t_sum'(1) + t_sum'(i_ya);
        m     = (p1 < p2) ? p1 : p2;
        old_w = t_sum'(i_old);
        thr   = i_girth - 7'd1;
        thr_w = t_sum'(thr);
        o_res.upd  = old_w > m;
        // girth zero means no pair ever leaves the set
        o_res.drop = o_res.upd && (i_girth != 7'd0) && (old_w >= thr_w) && (m < thr_w);
        o_res.dnew = m[DW-1:0];
    end

endmodule

// ===== rtl/incremental_distance_edge_insert_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                                   Handshake
// command   in         i_cmd, i_vertex_a, i_vertex_b             start & !busy
// result    out        o_status .. o_any_addable                 o_valid, one cycle
// config    in         i_cfg_idx, i_cfg_data                     i_cfg_we
//
// Clear sweeps all NR*NR distance entries (NR = MAX_VERTICES rounded up to a
// power of two; 4096 at the default), then reports. Add walks the upper
// triangle of pairs below nv through one relax unit, row by row: it reads
// d(x,a) and d(x,b), then per pair d(y,a), d(y,b) and d(x,y), then rewrites
// the row's addable bits. Report reads the pair, then scans the addable rows.
// Reset runs the clear sweep; busy is high until it ends.
// The receiver cannot stall: o_valid marks each item for one cycle.
module incremental_distance_edge_insert_top #(
    parameter int MAX_VERTICES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_vertex_a,
    input  logic [5:0]  i_vertex_b,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [6:0]  o_distance,
    output logic        o_adjacent,
    output logic        o_addable,
    output logic [5:0]  o_degree_a,
    output logic [5:0]  o_degree_b,
    output logic [10:0] o_edge_count,
    output logic        o_any_addable
);
    import idei_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NR  = 1 << VW;
    localparam int AW  = 2 * VW;
    localparam int KW  = (VW + 1 > 7) ? VW + 1 : 7;
    localparam int DGW = (VW > 6) ? VW : 6;
    localparam int EW  = (2 * VW > 11) ? 2 * VW : 11;
    localparam logic [6:0] NV_RST = (MAX_VERTICES > 64) ? 7'd64 : 7'(MAX_VERTICES);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_CLR  = 16'h0002,
        S_CHK  = 16'h0004,
        S_CHKW = 16'h0008,
        S_INS0 = 16'h0010,
        S_INS1 = 16'h0020,
        S_ROW  = 16'h0040,
        S_ROWW = 16'h0080,
        S_PXY  = 16'h0100,
        S_UPD  = 16'h0200,
        S_AR   = 16'h0400,
        S_AW   = 16'h0800,
        S_RPT  = 16'h1000,
        S_RPTW = 16'h2000,
        S_SCAN = 16'h4000,
        S_OUT  = 16'h8000
    } t_state;

    function automatic logic [AW-1:0] f_canon(input logic [VW-1:0] p, input logic [VW-1:0] q);
        return (p < q) ? {p, q} : {q, p};
    endfunction

    // control and command registers
    t_state          r_state, n_state;
    logic            r_boot, n_boot;
    logic [6:0]      r_numv, r_girth;
    logic [6:0]      r_nv, n_nv;
    logic [1:0]      r_cmd, n_cmd;
    logic [5:0]      r_a, n_a, r_b, n_b;
    logic            r_ain, n_ain, r_bin, n_bin;
    t_status         r_status, n_status;
    logic [AW-1:0]   r_clr, n_clr;
    logic [VW:0]     r_x, n_x, r_y, n_y, r_si, n_si;
    logic [VW-1:0]   r_sj, n_sj;
    logic            r_sv, n_sv, r_any, n_any;
    logic [EW-1:0]   r_edges, n_edges;
    logic            r_dg0, n_dg0, r_dg1, n_dg1;
    // datapath holding registers
    t_dist           r_xa, n_xa, r_xb, n_xb, r_ya, n_ya, r_yb, n_yb;
    logic [NR-1:0]   r_amask, n_amask, r_adjrow, n_adjrow, r_addrow, n_addrow;
    logic [DGW-1:0]  r_dega, n_dega, r_degb, n_degb;
    // result registers
    logic            r_valid, n_valid;
    logic [1:0]      r_ostat, n_ostat;
    logic [6:0]      r_odist, n_odist;
    logic            r_oadj, n_oadj, r_oadd, n_oadd;
    logic [5:0]      r_odega, n_odega, r_odegb, n_odegb;

    // memory ports
    logic            dist_we;
    logic [AW-1:0]   dist_wa, dist_ra0, dist_ra1;
    t_dist           dist_wd, dist_rd0, dist_rd1;
    logic            adj_we, add_we, deg_we;
    logic [VW-1:0]   adj_wa, add_wa, deg_wa, adj_ra, add_ra0, add_ra1;
    logic [NR-1:0]   adj_wd, add_wd, adj_rd, add_rd0, add_rd1;
    logic [DGW-1:0]  deg_wd, deg_rd0, deg_rd1;

    logic [VW-1:0]   va, vb, lo, hi, xv, yv;
    logic [VW:0]     x1, y1;
    t_dist           d0, d1;
    t_relax          rlx;
    logic [6:0]      nv_now;
    logic            a_in_now, b_in_now, pair_ok;
    logic [NR-1:0]   scan_mask;

    idei_ram #(.WIDTH(DW), .DEPTH(NR * NR)) u_dist (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_wa), .i_wdata(dist_wd),
        .i_raddr0(dist_ra0), .o_rdata0(dist_rd0), .i_raddr1(dist_ra1), .o_rdata1(dist_rd1)
    );

    idei_ram #(.WIDTH(NR), .DEPTH(NR)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_wa), .i_wdata(adj_wd),
        .i_raddr0(adj_ra), .o_rdata0(adj_rd), .i_raddr1(adj_ra), .o_rdata1()
    );

    // addable pairs, upper triangle only: row = lower vertex, bit = higher
    idei_ram #(.WIDTH(NR), .DEPTH(NR)) u_add (
        .i_clk(i_clk), .i_we(add_we), .i_waddr(add_wa), .i_wdata(add_wd),
        .i_raddr0(add_ra0), .o_rdata0(add_rd0), .i_raddr1(add_ra1), .o_rdata1(add_rd1)
    );

    idei_ram #(.WIDTH(DGW), .DEPTH(NR)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_wa), .i_wdata(deg_wd),
        .i_raddr0(va), .o_rdata0(deg_rd0), .i_raddr1(vb), .o_rdata1(deg_rd1)
    );

    idei_relax u_relax (
        .i_xa(r_xa), .i_xb(r_xb), .i_ya(r_ya), .i_yb(r_yb),
        .i_old(d0), .i_girth(r_girth), .o_res(rlx)
    );

    assign va = VW'(r_a);
    assign vb = VW'(r_b);
    assign lo = (va < vb) ? va : vb;
    assign hi = (va < vb) ? vb : va;
    assign xv = r_x[VW-1:0];
    assign yv = r_y[VW-1:0];
    assign x1 = r_x + 1'b1;
    assign y1 = r_y + 1'b1;
    // the stored diagonal is ignored: it reads as zero
    assign d0 = r_dg0 ? '0 : dist_rd0;
    assign d1 = r_dg1 ? '0 : dist_rd1;
    assign nv_now   = (int'(r_numv) > MAX_VERTICES) ? 7'(MAX_VERTICES) : r_numv;
    assign a_in_now = {1'b0, i_vertex_a} < nv_now;
    assign b_in_now = {1'b0, i_vertex_b} < nv_now;
    assign pair_ok  = r_ain && r_bin && (r_status != ST_BAD);

    always_comb begin
        for (int j = 0; j < NR; j++) begin
            scan_mask[j] = (j > int'(r_sj)) && (j < int'(r_nv));
        end
    end

    always_comb begin
        n_state = r_state;   n_boot = r_boot;     n_nv = r_nv;
        n_cmd = r_cmd;       n_a = r_a;           n_b = r_b;
        n_ain = r_ain;       n_bin = r_bin;       n_status = r_status;
        n_clr = r_clr;       n_x = r_x;           n_y = r_y;
        n_si = r_si;         n_sj = r_sj;         n_sv = r_sv;
        n_any = r_any;       n_edges = r_edges;
        n_dg0 = 1'b0;        n_dg1 = 1'b0;
        n_xa = r_xa;         n_xb = r_xb;         n_ya = r_ya;   n_yb = r_yb;
        n_amask = r_amask;   n_adjrow = r_adjrow; n_addrow = r_addrow;
        n_dega = r_dega;     n_degb = r_degb;
        n_valid = 1'b0;      n_ostat = r_ostat;   n_odist = r_odist;
        n_oadj = r_oadj;     n_oadd = r_oadd;     n_odega = r_odega; n_odegb = r_odegb;

        dist_we = 1'b0; dist_wa = f_canon(lo, hi); dist_wd = r_nv;
        dist_ra0 = f_canon(lo, hi); dist_ra1 = f_canon(lo, hi);
        adj_we = 1'b0; adj_wa = lo; adj_wd = '0; adj_ra = lo;
        add_we = 1'b0; add_wa = lo; add_wd = '1; add_ra0 = lo;
        add_ra1 = r_si[VW-1:0];
        deg_we = 1'b0; deg_wa = va; deg_wd = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd; n_a = i_vertex_a; n_b = i_vertex_b;
                    n_nv = nv_now; n_ain = a_in_now; n_bin = b_in_now;
                    if (i_cmd == CMD_CLEAR) begin
                        n_status = ST_OK;
                        n_clr    = '0;
                        n_state  = S_CLR;
                    end else if (!(a_in_now && b_in_now && (i_vertex_a != i_vertex_b))) begin
                        n_status = ST_BAD;
                        n_state  = S_RPT;
                    end else begin
                        n_status = ST_OK;
                        n_state  = (i_cmd == CMD_ADD) ? S_CHK : S_RPT;
                    end
                end
            end
            S_CLR: begin
                dist_we = 1'b1;
                dist_wa = r_clr;
                dist_wd = r_nv;
                if (r_clr[VW-1:0] == '0) begin
                    adj_we = 1'b1; adj_wa = r_clr[AW-1:VW]; adj_wd = '0;
                    add_we = 1'b1; add_wa = r_clr[AW-1:VW]; add_wd = '1;
                    deg_we = 1'b1; deg_wa = r_clr[AW-1:VW]; deg_wd = '0;
                end
                n_edges = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_RPT;
                end
            end
            S_CHK: begin
                n_state = S_CHKW;   // rows and degrees of the pair are read
            end
            S_CHKW: begin
                n_adjrow = adj_rd;
                n_addrow = add_rd0;
                n_dega   = deg_rd0;
                n_degb   = deg_rd1;
                if (adj_rd[hi]) begin
                    n_status = ST_DUP;
                    n_state  = S_RPT;
                end else begin
                    n_state = S_INS0;
                end
            end
            S_INS0: begin
                dist_we = 1'b1; dist_wa = f_canon(lo, hi); dist_wd = t_dist'(1);
                adj_we = 1'b1; adj_wa = lo; adj_wd = r_adjrow | (NR'(1) << hi);
                add_we = 1'b1; add_wa = lo; add_wd = r_addrow & ~(NR'(1) << hi);
                deg_we = 1'b1; deg_wa = va; deg_wd = r_dega + 1'b1;
                n_edges = r_edges + 1'b1;
                n_x     = '0;
                n_state = S_INS1;
            end
            S_INS1: begin
                deg_we = 1'b1; deg_wa = vb; deg_wd = r_degb + 1'b1;
                n_state = S_ROW;
            end
            S_ROW: begin
                // row x has pairs only when x+1 < nv
                if (KW'(x1) < KW'(r_nv)) begin
                    dist_ra0 = f_canon(xv, va); n_dg0 = (xv == va);
                    dist_ra1 = f_canon(xv, vb); n_dg1 = (xv == vb);
                    n_y      = x1;
                    n_amask  = '0;
                    n_state  = S_ROWW;
                end else begin
                    n_state = S_RPT;
                end
            end
            S_ROWW: begin
                n_xa = d0;
                n_xb = d1;
                dist_ra0 = f_canon(yv, va); n_dg0 = (yv == va);
                dist_ra1 = f_canon(yv, vb); n_dg1 = (yv == vb);
                n_state = S_PXY;
            end
            S_PXY: begin
                n_ya = d0;
                n_yb = d1;
                dist_ra0 = f_canon(xv, yv);
                n_state  = S_UPD;
            end
            S_UPD: begin
                if (rlx.upd) begin
                    dist_we = 1'b1; dist_wa = f_canon(xv, yv); dist_wd = rlx.dnew;
                    // d(x,a) or d(x,b) just shortened: rest of the row uses it
                    if (yv == va) begin
                        n_xa = rlx.dnew;
                    end
                    if (yv == vb) begin
                        n_xb = rlx.dnew;
                    end
                end
                if (rlx.drop) begin
                    n_amask[yv] = 1'b1;
                end
                // next pair of the row cannot alias the write above
                if (KW'(y1) < KW'(r_nv)) begin
                    n_y = y1;
                    dist_ra0 = f_canon(y1[VW-1:0], va); n_dg0 = (y1[VW-1:0] == va);
                    dist_ra1 = f_canon(y1[VW-1:0], vb); n_dg1 = (y1[VW-1:0] == vb);
                    n_state = S_PXY;
                end else begin
                    n_state = S_AR;
                end
            end
            S_AR: begin
                add_ra0 = xv;
                n_state = S_AW;
            end
            S_AW: begin
                add_we = 1'b1; add_wa = xv; add_wd = add_rd0 & ~r_amask;
                n_x     = x1;
                n_state = S_ROW;
            end
            S_RPT: begin
                n_dg0   = (va == vb);
                n_state = S_RPTW;
            end
            S_RPTW: begin
                n_ostat = r_status;
                n_odist = pair_ok ? d0 : 7'd0;
                n_oadj  = pair_ok && adj_rd[hi];
                n_oadd  = pair_ok && (va != vb) && add_rd0[hi];
                n_odega = r_ain ? deg_rd0[5:0] : 6'd0;
                n_odegb = r_bin ? deg_rd1[5:0] : 6'd0;
                n_si    = '0;
                n_sv    = 1'b0;
                n_any   = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // one addable row issued per cycle, checked in the cycle after it
                if (r_sv && ((add_rd1 & scan_mask) != '0)) begin
                    n_any = 1'b1;
                end
                if (KW'(r_si) < KW'(r_nv)) begin
                    n_sj = r_si[VW-1:0];
                    n_si = r_si + 1'b1;
                    n_sv = 1'b1;
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_valid = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_boot  <= 1'b1;
            r_clr   <= '0;
            r_nv    <= NV_RST;
            r_numv  <= 7'd64;
            r_girth <= 7'd5;
            r_valid <= 1'b0;
            r_edges <= '0;
            r_status <= ST_OK;
            r_sv    <= 1'b0;
            r_dg0   <= 1'b0;
            r_dg1   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
            r_clr   <= n_clr;
            r_nv    <= n_nv;
            r_valid <= n_valid;
            r_edges <= n_edges;
            r_status <= n_status;
            r_sv    <= n_sv;
            r_dg0   <= n_dg0;
            r_dg1   <= n_dg1;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_NUMV:  r_numv  <= i_cfg_data;
                    CFG_GIRTH: r_girth <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_cmd <= n_cmd;     r_a <= n_a;         r_b <= n_b;
        r_ain <= n_ain;     r_bin <= n_bin;
        r_x <= n_x;         r_y <= n_y;         r_si <= n_si;   r_sj <= n_sj;
        r_any <= n_any;
        r_xa <= n_xa;       r_xb <= n_xb;       r_ya <= n_ya;   r_yb <= n_yb;
        r_amask <= n_amask; r_adjrow <= n_adjrow; r_addrow <= n_addrow;
        r_dega <= n_dega;   r_degb <= n_degb;
        r_ostat <= n_ostat; r_odist <= n_odist; r_oadj <= n_oadj; r_oadd <= n_oadd;
        r_odega <= n_odega; r_odegb <= n_odegb;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_ostat;
    assign o_distance    = r_odist;
    assign o_adjacent    = r_oadj;
    assign o_addable     = r_oadd;
    assign o_degree_a    = r_odega;
    assign o_degree_b    = r_odegb;
    assign o_edge_count  = r_edges[10:0];
    assign o_any_addable = r_any;

    // the command register is held for the whole item
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !r_boot && $past(busy)) |-> $stable(r_cmd))
        else $error("command changed mid item");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    a_adj_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_adjacent) |-> (o_distance == 7'd1) && !o_addable)
        else $error("edge reported without unit distance");

    a_bad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_BAD)) |-> (o_distance == 7'd0) && !o_adjacent)
        else $error("bad pair reported pair data");

endmodule

// ===== sim/tb_incremental_distance_edge_insert_top.sv =====
`timescale 1ns / 1ps
module tb_incremental_distance_edge_insert_top;
    import idei_pkg::*;

    localparam int NMAX      = 64;
    localparam int IDLE_LIMIT = 40000;   // watchdog bound; must exceed the longest clear sweep or add

    // one command item
    typedef struct packed {
        t_cmd       cmd;
        logic [5:0] va;
        logic [5:0] vb;
    } t_item;

    // one result item
    typedef struct packed {
        t_status     status;
        logic [6:0]  distance;
        logic        adjacent;
        logic        addable;
        logic [5:0]  deg_a;
        logic [5:0]  deg_b;
        logic [10:0] edges;
        logic        any_add;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [5:0]  i_vertex_a = '0;
    logic [5:0]  i_vertex_b = '0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [6:0]  o_distance;
    logic        o_adjacent;
    logic        o_addable;
    logic [5:0]  o_degree_a;
    logic [5:0]  o_degree_b;
    logic [10:0] o_edge_count;
    logic        o_any_addable;

    incremental_distance_edge_insert_top #(.MAX_VERTICES(NMAX)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- graph shadow ----------------
    int unsigned nv_reg = 64;
    int unsigned girth_reg = 5;
    bit          adj_m [NMAX][NMAX];
    int          dist_m [NMAX][NMAX];
    bit          addable_m [NMAX][NMAX];
    int          deg [NMAX];
    int          edge_tot;

    t_item  pending_items[$];
    t_reply expected_replies[$];
    int     fail_count = 0;
    int     idle_cycles = 0;

    function automatic int active_n();
        return (nv_reg > NMAX) ? NMAX : nv_reg;
    endfunction

    function automatic void wipe_graph();
        int n;
        n = active_n();
        for (int i = 0; i < NMAX; i++) begin
            deg[i] = 0;
            for (int j = 0; j < NMAX; j++) begin
                adj_m[i][j]     = 0;
                dist_m[i][j]    = (i == j) ? 0 : n;
                addable_m[i][j] = (i != j);
            end
        end
        edge_tot = 0;
    endfunction

    // insert edge a-b and relax every pair through it
    function automatic void link_vertices(int a, int b);
        int n, thr, p1, p2, m, old;
        n = active_n();
        thr = int'(girth_reg) - 1;
        adj_m[a][b] = 1; adj_m[b][a] = 1;
        edge_tot++; deg[a]++; deg[b]++;
        dist_m[a][b] = 1; dist_m[b][a] = 1;
        addable_m[a][b] = 0; addable_m[b][a] = 0;
        for (int x = 0; x < n; x++)
            for (int y = x + 1; y < n; y++) begin
                p1 = dist_m[x][a] + 1 + dist_m[y][b];
                p2 = dist_m[x][b] + 1 + dist_m[y][a];
                m = (p1 < p2) ? p1 : p2;
                old = dist_m[x][y];
                if (old > m) begin
                    if (old >= thr && m < thr) begin
                        addable_m[x][y] = 0; addable_m[y][x] = 0;
                    end
                    dist_m[x][y] = m; dist_m[y][x] = m;
                end
            end
    endfunction

    function automatic t_reply apply_command(t_item it);
        t_reply r;
        int n, a, b;
        bit a_in, b_in, ok, pair_ok;
        a = it.va; b = it.vb;
        if (it.cmd == CMD_CLEAR) wipe_graph();
        n = active_n();
        a_in = a < n; b_in = b < n;
        ok = a_in && b_in && a != b;
        r.status = ST_OK;
        if (it.cmd == CMD_ADD) begin
            if (!ok) r.status = ST_BAD;
            else if (adj_m[a][b]) r.status = ST_DUP;
            else link_vertices(a, b);
        end else if (it.cmd != CMD_CLEAR && !ok) begin
            r.status = ST_BAD;
        end
        pair_ok = a_in && b_in && r.status != ST_BAD;
        r.distance = pair_ok ? 7'(dist_m[a][b]) : '0;
        r.adjacent = pair_ok ? adj_m[a][b] : 1'b0;
        r.addable  = pair_ok ? addable_m[a][b] : 1'b0;
        r.deg_a    = a_in ? 6'(deg[a]) : '0;
        r.deg_b    = b_in ? 6'(deg[b]) : '0;
        r.edges    = 11'(edge_tot);
        r.any_add  = 1'b0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (addable_m[i][j]) r.any_add = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // ---------------- driver ----------------
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_replies.push_back(apply_command(t_item'({i_cmd, i_vertex_a,
                                                                  i_vertex_b})));
            end
            // start stays high while the same item waits; changes only once taken
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_items.size() > 0 && !(start && !busy
                             && pending_items.size() == 0)) begin
                    t_item it;
                    it = pending_items.pop_front();
                    i_cmd <= it.cmd; i_vertex_a <= it.va; i_vertex_b <= it.vb;
                    start <= 1'b1;
                    // short gaps mostly, sometimes long
                    gap_left <= ($urandom_range(0, 9) < 6) ? 0 :
                                ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                            : $urandom_range(20, 80);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                t_reply w;
                idle_cycles <= 0;
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected result item", 1, 0);
                end else begin
                    w = expected_replies.pop_front();
                    if (o_status != w.status) report_mismatch("status", o_status, w.status);
                    if (o_distance != w.distance)
                        report_mismatch("distance", o_distance, w.distance);
                    if (o_adjacent != w.adjacent)
                        report_mismatch("adjacent", o_adjacent, w.adjacent);
                    if (o_addable != w.addable)
                        report_mismatch("addable", o_addable, w.addable);
                    if (o_degree_a != w.deg_a) report_mismatch("degree_a", o_degree_a, w.deg_a);
                    if (o_degree_b != w.deg_b) report_mismatch("degree_b", o_degree_b, w.deg_b);
                    if (o_edge_count != w.edges)
                        report_mismatch("edge_count", o_edge_count, w.edges);
                    if (o_any_addable != w.any_add)
                        report_mismatch("any_addable", o_any_addable, w.any_add);
                end
            end else if (!(start && !busy)) begin
                idle_cycles <= idle_cycles + 1;
            end else begin
                idle_cycles <= 0;
            end
            // watchdog: nothing taken or returned for too long
            if (idle_cycles > IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_item(t_cmd c, int a, int b);
        pending_items.push_back(t_item'({c, 6'(a), 6'(b)}));
    endtask

    // wait until every queued item has been taken and answered
    task automatic drain();
        while (pending_items.size() > 0 || start || gap_left > 0
               || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= 7'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NUMV) nv_reg = val; else girth_reg = val;
    endtask

    // random phase: clear, then mostly adds between live vertices with reads
    task automatic random_phase(int count);
        int n;
        n = active_n();
        queue_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        for (int k = 0; k < count; k++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 55)
                queue_item(CMD_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
            else if (sel < 85)
                queue_item(t_cmd'($urandom_range(2, 3)), $urandom_range(0, n - 1),
                           $urandom_range(0, n - 1));
            else if (sel < 97)
                queue_item(t_cmd'($urandom_range(1, 3)), $urandom_range(0, 63),
                           $urandom_range(0, 63));
            else
                queue_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    initial begin
        wipe_graph();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults, extremes, every command, each special case
        queue_item(CMD_READ, 0, 63);
        queue_item(CMD_ADD, 0, 63);
        queue_item(CMD_ADD, 63, 0);          // existing edge
        queue_item(CMD_ADD, 5, 5);           // self-loop
        queue_item(CMD_ADD, 63, 1);
        queue_item(CMD_ADD, 1, 2);
        queue_item(CMD_READ, 0, 2);
        queue_item(CMD_ALT, 2, 0);           // command three reads
        queue_item(CMD_READ, 7, 7);
        queue_item(CMD_CLEAR, 63, 0);
        drain();

        // register change alone leaves state; small graph, out-of-range pairs
        write_reg(CFG_NUMV, 2);
        write_reg(CFG_GIRTH, 3);
        queue_item(CMD_READ, 0, 1);
        queue_item(CMD_CLEAR, 1, 40);        // clear with out-of-range vertex
        queue_item(CMD_ADD, 0, 1);
        queue_item(CMD_ADD, 0, 2);           // out of range
        queue_item(CMD_READ, 1, 0);
        queue_item(CMD_READ, 2, 1);
        drain();

        write_reg(CFG_NUMV, 0);              // degenerate setting
        write_reg(CFG_GIRTH, 0);             // low girth: no drops
        queue_item(CMD_CLEAR, 0, 0);
        queue_item(CMD_ADD, 0, 1);
        drain();
        write_reg(CFG_NUMV, 127);            // saturates at 64
        write_reg(CFG_GIRTH, 127);
        queue_item(CMD_CLEAR, 42, 21);
        queue_item(CMD_ADD, 42, 21);
        queue_item(CMD_ADD, 21, 63);
        drain();

        // random phases over several settings
        write_reg(CFG_NUMV, 8);  write_reg(CFG_GIRTH, 4);
        random_phase(70);
        drain();                             // sender holds until all answered
        write_reg(CFG_NUMV, 12); write_reg(CFG_GIRTH, 64);
        random_phase(60);
        drain();
        write_reg(CFG_NUMV, 5);  write_reg(CFG_GIRTH, 3);
        random_phase(50);
        drain();
        write_reg(CFG_NUMV, 16); write_reg(CFG_GIRTH, 5);
        random_phase(55);
        drain();
        write_reg(CFG_NUMV, 64); write_reg(CFG_GIRTH, 6);
        random_phase(30);
        drain();

        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
